// ===== hw/rtl/csseq_pkg.sv =====
// Types and constants shared by the code sort sequencer.
package csseq_pkg;

    // Sequence phases.
    localparam logic [2:0] PH_WAIT  = 3'd0;
    localparam logic [2:0] PH_DELAY = 3'd1;
    localparam logic [2:0] PH_MOVE  = 3'd2;
    localparam logic [2:0] PH_SERVO = 3'd3;
    localparam logic [2:0] PH_HOME  = 3'd4;

    // Fault codes.
    localparam logic [1:0] FLT_NONE = 2'd0;
    localparam logic [1:0] FLT_TEMP = 2'd1;
    localparam logic [1:0] FLT_CURR = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_WAIT_STEPS    = 3'd0;
    localparam logic [2:0] REG_TEMP_LIMIT    = 3'd1;
    localparam logic [2:0] REG_CURRENT_LIMIT = 3'd2;
    localparam logic [2:0] REG_FIRST_POS     = 3'd3;
    localparam logic [2:0] REG_POS_PITCH     = 3'd4;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Register reset values.
    localparam logic [15:0]       RST_WAIT_STEPS    = 16'd200;
    localparam logic signed [7:0] RST_TEMP_LIMIT    = 8'sd30;
    localparam logic [15:0]       RST_CURRENT_LIMIT = 16'd1200;
    localparam logic [11:0]       RST_FIRST_POS     = 12'd30;
    localparam logic [11:0]       RST_POS_PITCH     = 12'd70;

    localparam logic [3:0]  NO_TARGET   = 4'd10;
    localparam logic [7:0]  NO_CODE     = 8'hFF;
    localparam logic [7:0]  ASCII_ZERO  = 8'h30;
    localparam logic [7:0]  ASCII_NINE  = 8'h39;
    localparam logic [15:0] DELAY_MAX   = 16'hFFFF;
    localparam logic [15:0] HOME_POS_MM = 16'd0;

    typedef struct packed {
        logic              code_valid;
        logic [7:0]        scan_code;
        logic              screw_idle;
        logic              screw_cmd_taken;
        logic              servo_idle;
        logic signed [7:0] driver_temp_c;
        logic [15:0]       phase_current_ma;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  fault;
        logic [7:0]  last_code;
        logic        move_pending;
        logic [15:0] move_target_mm;
        logic        servo_start;
        logic        servo_dir;
        logic        stop_pulse;
        logic [31:0] sorted_count;
    } t_out_item;

endpackage

// ===== hw/rtl/code_sort_sequencer_with_fault_latch.sv =====
// Code sort sequencer with latched fault check, one control tick per word.
// The result word is registered: the input register holds the accepted word, then the sequence step
// writes state and the result register together.
// Throughput: one word per cycle while the output is not stalled.
// Reset (synchronous, active low) clears the sequence, the fault latch and the
// counters and loads the configuration registers with their default values.
module code_sort_sequencer_with_fault_latch
    import csseq_pkg::*;
#(
    parameter int NUM_TARGETS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    localparam logic [7:0] NumTgt8 = 8'(NUM_TARGETS);
    localparam logic [3:0] NumTgt4 = 4'(NUM_TARGETS);

    // Configuration.
    logic [15:0]       r_wait_steps;
    logic signed [7:0] r_temp_limit;
    logic [15:0]       r_current_limit;
    logic [11:0]       r_first_pos;
    logic [11:0]       r_pos_pitch;

    // Pipeline registers.
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    // Sequence state.
    logic [2:0]  r_phase,  n_phase;
    logic [1:0]  r_fault,  n_fault;
    logic [3:0]  r_target, n_target;
    logic [15:0] r_delay,  n_delay;
    logic        r_pending, n_pending;
    logic [15:0] r_goal,   n_goal;
    logic [7:0]  r_seen,   n_seen;
    logic [31:0] r_count,  n_count;

    logic        step;
    logic        n_servo_start;
    logic        n_stop;
    logic        code_ok;
    logic [7:0]  ascii_digit;
    logic [3:0]  code_idx;
    logic [14:0] pitch_ofs;
    t_out_item   n_out;

    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    // Code decode: binary 0..N-1 or ASCII digit below N.
    always_comb begin
        ascii_digit = r_in.scan_code - ASCII_ZERO;
        if (r_in.scan_code < NumTgt8) begin
            code_ok  = 1'b1;
            code_idx = r_in.scan_code[3:0];
        end else if (r_in.scan_code >= ASCII_ZERO && r_in.scan_code <= ASCII_NINE
                     && ascii_digit < NumTgt8) begin
            code_ok  = 1'b1;
            code_idx = ascii_digit[3:0];
        end else begin
            code_ok  = 1'b0;
            code_idx = NO_TARGET;
        end
    end

    // Targets come in pairs: one position per pair, direction from the low bit.
    assign pitch_ofs = 15'(r_pos_pitch) * 15'(r_target[3:1]);

    always_comb begin
        n_phase       = r_phase;
        n_fault       = r_fault;
        n_target      = r_target;
        n_delay       = r_delay;
        n_pending     = r_pending;
        n_goal        = r_goal;
        n_seen        = r_seen;
        n_count       = r_count;
        n_servo_start = 1'b0;
        n_stop        = 1'b0;

        if (r_fault == FLT_NONE) begin
            if (r_in.screw_cmd_taken) begin
                n_pending = 1'b0;
            end
            // Over-temperature wins over over-current.
            if (r_in.driver_temp_c > r_temp_limit) begin
                n_fault = FLT_TEMP;
            end else if (r_in.phase_current_ma > r_current_limit) begin
                n_fault = FLT_CURR;
            end
        end

        if (r_fault == FLT_NONE && n_fault != FLT_NONE) begin
            n_pending = 1'b0;
            n_stop    = 1'b1;
        end else if (r_fault == FLT_NONE) begin
            case (r_phase)
                PH_WAIT: begin
                    if (r_in.code_valid) begin
                        n_seen = r_in.scan_code;
                        if (code_ok) begin
                            n_target = code_idx;
                            n_delay  = '0;
                            n_count  = r_count + 32'd1;
                            n_phase  = PH_DELAY;
                        end
                    end
                end
                PH_DELAY: begin
                    if (r_delay != DELAY_MAX) begin
                        n_delay = r_delay + 16'd1;
                    end
                    if (n_delay >= r_wait_steps) begin
                        n_goal    = 16'(r_first_pos) + 16'(pitch_ofs);
                        n_pending = 1'b1;
                        n_phase   = PH_MOVE;
                    end
                end
                PH_MOVE: begin
                    if (!n_pending && r_in.screw_idle) begin
                        n_servo_start = 1'b1;
                        n_phase       = PH_SERVO;
                    end
                end
                PH_SERVO: begin
                    if (r_in.servo_idle) begin
                        n_goal    = HOME_POS_MM;
                        n_pending = 1'b1;
                        n_phase   = PH_HOME;
                    end
                end
                PH_HOME: begin
                    if (!n_pending && r_in.screw_idle) begin
                        n_phase = PH_WAIT;
                    end
                end
                default: begin
                    n_phase = PH_WAIT;
                end
            endcase
        end

        n_out.phase          = n_phase;
        n_out.fault          = n_fault;
        n_out.last_code      = n_seen;
        n_out.move_pending   = n_pending;
        n_out.move_target_mm = n_goal;
        n_out.servo_start    = n_servo_start;
        n_out.servo_dir      = (n_target < NumTgt4) ? n_target[0] : 1'b0;
        n_out.stop_pulse     = n_stop;
        n_out.sorted_count   = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_steps    <= RST_WAIT_STEPS;
            r_temp_limit    <= RST_TEMP_LIMIT;
            r_current_limit <= RST_CURRENT_LIMIT;
            r_first_pos     <= RST_FIRST_POS;
            r_pos_pitch     <= RST_POS_PITCH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WAIT_STEPS:    r_wait_steps    <= i_cfg_data;
                REG_TEMP_LIMIT:    r_temp_limit    <= i_cfg_data[7:0];
                REG_CURRENT_LIMIT: r_current_limit <= i_cfg_data;
                REG_FIRST_POS:     r_first_pos     <= i_cfg_data[11:0];
                REG_POS_PITCH:     r_pos_pitch     <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_WAIT;
            r_fault     <= FLT_NONE;
            r_target    <= NO_TARGET;
            r_delay     <= '0;
            r_pending   <= 1'b0;
            r_goal      <= '0;
            r_seen      <= NO_CODE;
            r_count     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_fault     <= n_fault;
                r_target    <= n_target;
                r_delay     <= n_delay;
                r_pending   <= n_pending;
                r_goal      <= n_goal;
                r_seen      <= n_seen;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Once tripped, the fault code never changes until reset.
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault != FLT_NONE |=> r_fault == $past(r_fault))
        else $error("fault latch changed after tripping");

    // A stop pulse is only reported together with a latched fault.
    a_stop_has_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.stop_pulse |-> r_out.fault != FLT_NONE)
        else $error("stop pulse without fault");

    // A servo start is only reported on entry to the servo phase.
    a_servo_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.servo_start |-> r_out.phase == PH_SERVO)
        else $error("servo start outside servo phase");

    // The sequence never holds an unused phase code.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_WAIT || r_phase == PH_DELAY || r_phase == PH_MOVE
        || r_phase == PH_SERVO || r_phase == PH_HOME)
        else $error("sequence phase out of range");

endmodule
